### design/osf_pkg.sv
// osf_pkg: shared constants for the overlap-save input framer
// used by osf_ring, osf_emit and overlap_save_framer; no dependencies
package osf_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam int INDEX_W  = 6;
  localparam int REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SPECTRAL = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOP      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FRAMES   = 2'd3;

  // register reset values
  localparam logic             SPECTRAL_RST = 1'b0;
  localparam logic [CFG_W-1:0] HOP_RST      = 7'd16;
  localparam logic [CFG_W-1:0] BLOCK_RST    = 7'd64;
  localparam logic [CFG_W-1:0] FRAMES_RST   = 7'd64;

  localparam logic [SAMPLE_W-1:0] POS_ZERO = 32'h0000_0000;

  // exponent all ones: nan or infinity
  function automatic logic is_nonfinite(logic [SAMPLE_W-1:0] bits);
    return &bits[30:23];
  endfunction

endpackage

### design/osf_ring.sv
// osf_ring: sample ring memory with one write port and one registered read port
// entry valid flags give the all-zero reset state; uses osf_pkg
module osf_ring #(
  parameter int CAPACITY = osf_pkg::CAPACITY_DEF,
  parameter int PW       = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [PW-1:0]                 wr_addr_i,
  input  logic [osf_pkg::SAMPLE_W-1:0]  wr_data_i,
  input  logic                          clr_en_i,
  input  logic [PW-1:0]                 clr_addr_i,
  input  logic                          rd_en_i,
  input  logic [PW-1:0]                 rd_addr_i,
  output logic [osf_pkg::SAMPLE_W-1:0]  rd_data_o
);

  logic [osf_pkg::SAMPLE_W-1:0] mem [CAPACITY];
  logic [CAPACITY-1:0]          vld_q;
  logic [osf_pkg::SAMPLE_W-1:0] rd_data_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end else if (clr_en_i) begin
        vld_q[clr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // entries never written, or cleared, read as +0.0
  assign rd_data_o = rd_vld_q ? rd_data_q : osf_pkg::POS_ZERO;

endmodule

### design/osf_emit.sv
// osf_emit: frame read sequencer, memory data stage and output register
// drives the read and clear ports of osf_ring; uses osf_pkg
module osf_emit #(
  parameter int CAPACITY = osf_pkg::CAPACITY_DEF,
  parameter int PW       = $clog2(CAPACITY),
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [PW-1:0]                 start_addr_i,
  input  logic [LW-1:0]                 len_i,
  input  logic                          spectral_i,
  output logic                          busy_o,
  output logic                          rd_en_o,
  output logic [PW-1:0]                 rd_addr_o,
  input  logic [osf_pkg::SAMPLE_W-1:0]  rd_data_i,
  output logic                          clr_en_o,
  output logic [PW-1:0]                 clr_addr_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [osf_pkg::SAMPLE_W-1:0]  frame_sample_o,
  output logic [osf_pkg::INDEX_W-1:0]   frame_index_o,
  output logic                          frame_last_o
);

  localparam logic [PW-1:0] LAST_ADDR = PW'(CAPACITY - 1);

  logic [LW-1:0]                rem_q, rem_d;
  logic [PW-1:0]                addr_q, addr_d;
  logic [osf_pkg::INDEX_W-1:0]  idx_q, idx_d;
  logic                         rv_q;
  logic [osf_pkg::INDEX_W-1:0]  s1_idx_q;
  logic                         s1_last_q;
  logic [PW-1:0]                s1_addr_q;
  logic                         ov_q;
  logic [osf_pkg::SAMPLE_W-1:0] o_data_q;
  logic [osf_pkg::INDEX_W-1:0]  o_idx_q;
  logic                         o_last_q;
  logic                         adv, issue, zap;

  // memory data moves on when the output register is free or being taken
  assign adv   = rv_q && (!ov_q || out_ready_i);
  assign issue = (rem_q != '0) && (!rv_q || adv);
  assign zap   = spectral_i && osf_pkg::is_nonfinite(rd_data_i);

  assign busy_o     = (rem_q != '0) || rv_q;
  assign rd_en_o    = issue;
  assign rd_addr_o  = addr_q;
  assign clr_en_o   = adv && zap;
  assign clr_addr_o = s1_addr_q;

  always_comb begin
    rem_d  = rem_q;
    addr_d = addr_q;
    idx_d  = idx_q;
    if (start_i) begin
      rem_d  = len_i;
      addr_d = start_addr_i;
      idx_d  = '0;
    end else if (issue) begin
      rem_d  = rem_q - LW'(1);
      addr_d = (addr_q == LAST_ADDR) ? '0 : addr_q + PW'(1);
      idx_d  = idx_q + osf_pkg::INDEX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      addr_q <= '0;
      idx_q  <= '0;
      rv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      addr_q <= addr_d;
      idx_q  <= idx_d;
      if (issue) begin
        rv_q <= 1'b1;
      end else if (adv) begin
        rv_q <= 1'b0;
      end
      if (adv) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= idx_q;
      s1_last_q <= (rem_q == LW'(1));
      s1_addr_q <= addr_q;
    end
    if (adv) begin
      o_data_q <= zap ? osf_pkg::POS_ZERO : rd_data_i;
      o_idx_q  <= s1_idx_q;
      o_last_q <= s1_last_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign frame_sample_o = o_data_q;
  assign frame_index_o  = o_idx_q;
  assign frame_last_o   = o_last_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o)
    else $error("frame start while a frame is still being read");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (len_i != '0) |=> busy_o)
    else $error("non-empty frame start did not begin reading");

  a_last_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && s1_last_q |-> rem_q == '0)
    else $error("reads left after the last sample of a frame");

  a_clear_spectral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_en_o |-> spectral_i && rv_q)
    else $error("ring entry cleared outside spectral framing");

endmodule

### design/overlap_save_framer.sv
// overlap_save_framer: top level, configuration registers, write pointer and hop counter
// instantiates osf_ring and osf_emit; uses osf_pkg
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   sample_in_i
//   out      out_valid_o / out_ready_i frame_sample_o, frame_index_o, frame_last_o
//   cfg      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a sample is written into the ring in the cycle it is accepted, unless spectral mode drops it
// when a hop completes, the frame is read from the ring at one sample per cycle
// through the registered memory read; input is held off until the last sample
// of the frame has reached the output register; output stalls pause the reads
// and extend that hold; reset clears all ring entries to +0.0 at once
module overlap_save_framer #(
  parameter int CAPACITY = osf_pkg::CAPACITY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [osf_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [osf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [osf_pkg::SAMPLE_W-1:0]   sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [osf_pkg::SAMPLE_W-1:0]   frame_sample_o,
  output logic [osf_pkg::INDEX_W-1:0]    frame_index_o,
  output logic                           frame_last_o
);

  localparam int PW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int SW = LW + 1;
  localparam int CW = osf_pkg::CFG_W;
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_ADDR = PW'(CAPACITY - 1);

  logic          spectral_q;
  logic [CW-1:0] hop_q, block_q, frames_q;
  logic [PW-1:0] wp_q, wp_d;
  logic [CW-1:0] hc_q, hc_d;

  logic          accept, drop, emit, start, busy;
  logic [CW-1:0] hop_eff, blk_eff, hop_cap, blk_cap, hc_inc;
  logic [SW-1:0] start_sum;
  logic [PW-1:0] start_addr;
  logic [osf_pkg::SAMPLE_W-1:0] wr_data;

  logic          rd_en, clr_en;
  logic [PW-1:0] rd_addr, clr_addr;
  logic [osf_pkg::SAMPLE_W-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spectral_q <= osf_pkg::SPECTRAL_RST;
      hop_q      <= osf_pkg::HOP_RST;
      block_q    <= osf_pkg::BLOCK_RST;
      frames_q   <= osf_pkg::FRAMES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        osf_pkg::REG_SPECTRAL: spectral_q <= cfg_data_i[0];
        osf_pkg::REG_HOP:      hop_q      <= cfg_data_i;
        osf_pkg::REG_BLOCK:    block_q    <= cfg_data_i;
        osf_pkg::REG_FRAMES:   frames_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective hop and frame length
  always_comb begin
    hop_cap = (hop_q < CAP_C) ? hop_q : CAP_C;
    blk_cap = (block_q < CAP_C) ? block_q : CAP_C;
    if (spectral_q) begin
      hop_eff = hop_cap;
      blk_eff = block_q;
    end else begin
      hop_eff = (hop_cap < frames_q) ? hop_cap : frames_q;
      blk_eff = (blk_cap < frames_q) ? blk_cap : frames_q;
    end
    if (hop_eff == '0) begin
      hop_eff = CW'(1);
    end
  end

  assign drop    = spectral_q && (block_q > CAP_C);
  assign accept  = in_valid_i && in_ready_o;
  assign wr_data = (spectral_q && osf_pkg::is_nonfinite(sample_in_i)) ?
                   osf_pkg::POS_ZERO : sample_in_i;
  assign hc_inc  = hc_q + CW'(1);
  assign emit    = hc_inc >= hop_eff;
  assign start   = accept && !drop && emit && (blk_eff != '0);

  always_comb begin
    wp_d = wp_q;
    hc_d = hc_q;
    if (accept && !drop) begin
      wp_d = (wp_q == LAST_ADDR) ? '0 : wp_q + PW'(1);
      hc_d = emit ? '0 : hc_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      hc_q <= '0;
    end else begin
      wp_q <= wp_d;
      hc_q <= hc_d;
    end
  end

  // oldest sample of the frame: new write pointer minus frame length, wrapped
  always_comb begin
    start_sum = SW'(wp_d) + SW'(CAPACITY) - SW'(blk_eff[LW-1:0]);
    if (start_sum >= SW'(CAPACITY)) begin
      start_sum = start_sum - SW'(CAPACITY);
    end
    start_addr = start_sum[PW-1:0];
  end

  assign in_ready_o = !busy;

  osf_ring #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && !drop),
    .wr_addr_i  (wp_q),
    .wr_data_i  (wr_data),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  osf_emit #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .LW       (LW)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .start_addr_i   (start_addr),
    .len_i          (blk_eff[LW-1:0]),
    .spectral_i     (spectral_q),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .clr_en_o       (clr_en),
    .clr_addr_o     (clr_addr),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_sample_o (frame_sample_o),
    .frame_index_o  (frame_index_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

### test/overlap_save_framer_tb.sv
`timescale 1ns / 1ps
// overlap_save_framer_tb: self-checking bench for the overlap-save input framer
// directed rows then random register phases; frames checked against a predictor or typed expected values
// depends on osf_pkg and overlap_save_framer
module overlap_save_framer_tb;

  localparam int RING_DEPTH      = osf_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS    = 130;
  localparam int CALM_ITEMS      = 30;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = osf_pkg::CAPACITY_DEF + 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam longint LIMIT_NS    = 4_000_000;

  typedef struct packed {
    logic [osf_pkg::SAMPLE_W-1:0] smp;
    logic [osf_pkg::INDEX_W-1:0]  pos;
    logic                         last;
  } frame_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [osf_pkg::REG_IDX_W-1:0] idx;
    logic [osf_pkg::CFG_W-1:0]     data;
    logic [osf_pkg::SAMPLE_W-1:0]  smp;
    logic                          one_beat;  // typed row: one-sample frame of want, else nothing
    logic [osf_pkg::SAMPLE_W-1:0]  want;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [osf_pkg::REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [osf_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [osf_pkg::SAMPLE_W-1:0]  sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b1;
  logic [osf_pkg::SAMPLE_W-1:0]  frame_sample_o;
  logic [osf_pkg::INDEX_W-1:0]   frame_index_o;
  logic                          frame_last_o;

  overlap_save_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_sample_o (frame_sample_o),
    .frame_index_o  (frame_index_o),
    .frame_last_o   (frame_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor image of the block
  logic [osf_pkg::SAMPLE_W-1:0] ring_img [RING_DEPTH];
  int unsigned                  wr_ptr;
  int unsigned                  since_frame;
  logic                         cfg_spec;
  logic [osf_pkg::CFG_W-1:0]    cfg_hop;
  logic [osf_pkg::CFG_W-1:0]    cfg_blk;
  logic [osf_pkg::CFG_W-1:0]    cfg_calls;

  frame_beat_t pending_beats[$];
  frame_beat_t got_beat;
  stim_row_t   dir_rows[$];
  int          errors;
  int          beats_checked;
  int          samples_sent;
  int          samples_dropped;
  int          phase_cnt;
  bit          calm_tail;

  function automatic bit exp_all_ones(logic [osf_pkg::SAMPLE_W-1:0] s);
    return s[30:23] == 8'hFF;
  endfunction

  // advances the image by one sample; returns the frame length, 0 if no frame, -1 if the sample is dropped
  function automatic int predict_frame_beats(logic [osf_pkg::SAMPLE_W-1:0] s, bit keep);
    int unsigned hop;
    int unsigned blk;
    int unsigned rp;
    int unsigned i;
    logic [osf_pkg::SAMPLE_W-1:0] v;
    frame_beat_t b;
    hop = (cfg_hop < RING_DEPTH) ? cfg_hop : RING_DEPTH;
    if (cfg_spec) begin
      blk = cfg_blk;
      if (blk > RING_DEPTH) return -1;
      if (exp_all_ones(s)) s = osf_pkg::POS_ZERO;
    end else begin
      blk = (cfg_blk < RING_DEPTH) ? cfg_blk : RING_DEPTH;
      if (cfg_calls < blk) blk = cfg_calls;
      if (cfg_calls < hop) hop = cfg_calls;
    end
    if (hop == 0) hop = 1;
    ring_img[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    since_frame = (since_frame + 1) & 32'h7F;
    if (since_frame < hop) return 0;
    since_frame = 0;
    for (i = 0; i < blk; i++) begin
      rp = (wr_ptr + RING_DEPTH - blk + i) % RING_DEPTH;
      v = ring_img[rp];
      // spectral reads scrub non-finite words left behind by time mode
      if (cfg_spec && exp_all_ones(v)) begin
        v = osf_pkg::POS_ZERO;
        ring_img[rp] = osf_pkg::POS_ZERO;
      end
      b.smp = v;
      b.pos = osf_pkg::INDEX_W'(i);
      b.last = (i + 1 == blk);
      if (keep) pending_beats.push_back(b);
    end
    return blk;
  endfunction

  function automatic stim_row_t cfg_row(logic [osf_pkg::REG_IDX_W-1:0] idx,
                                        logic [osf_pkg::CFG_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic stim_row_t smp_row(logic [osf_pkg::SAMPLE_W-1:0] s);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.smp = s;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [osf_pkg::SAMPLE_W-1:0] s, logic one_beat,
                                          logic [osf_pkg::SAMPLE_W-1:0] want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.smp = s;
    r.one_beat = one_beat;
    r.want = want;
    return r;
  endfunction

  function automatic logic [osf_pkg::SAMPLE_W-1:0] rand_sample();
    logic [osf_pkg::SAMPLE_W-1:0] s;
    s = $urandom();
    case ($urandom_range(0, 9))
      0: s[30:0] = {8'hFF, 23'h0};  // infinity, either sign
      1: s[30:23] = 8'hFF;          // nan, mostly
      2: s[30:0] = '0;              // signed zero
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(logic [osf_pkg::REG_IDX_W-1:0] idx, logic [osf_pkg::CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      osf_pkg::REG_SPECTRAL: cfg_spec = data[0];
      osf_pkg::REG_HOP:      cfg_hop = data;
      osf_pkg::REG_BLOCK:    cfg_blk = data;
      osf_pkg::REG_FRAMES:   cfg_calls = data;
      default: ;
    endcase
  endtask

  // hold the sender until every predicted frame sample is out, then let the block settle
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [osf_pkg::SAMPLE_W-1:0] s, bit keep, output int n_beats);
    in_valid_i <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_beats = predict_frame_beats(s, keep);
    samples_sent++;
    if (n_beats < 0) samples_dropped++;
  endtask

  task automatic sender_gap();
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic random_setting();
    logic [osf_pkg::CFG_W-1:0] v;
    if ($urandom_range(0, 3) == 0) begin
      // hop change alone, while a partial hop may be pending
      write_reg(osf_pkg::REG_HOP, osf_pkg::CFG_W'($urandom_range(0, 6)));
      return;
    end
    v = osf_pkg::CFG_W'($urandom());
    write_reg(osf_pkg::REG_SPECTRAL, v);  // only bit 0 matters
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = osf_pkg::CFG_W'($urandom_range(65, 127));
      2: v = 7'd64;
      default: v = osf_pkg::CFG_W'($urandom_range(1, 8));
    endcase
    write_reg(osf_pkg::REG_HOP, v);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = osf_pkg::CFG_W'($urandom_range(65, 127));
      2: v = 7'd64;
      default: v = osf_pkg::CFG_W'($urandom_range(1, 16));
    endcase
    write_reg(osf_pkg::REG_BLOCK, v);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = osf_pkg::CFG_W'($urandom_range(0, 127));
      2: v = 7'd127;
      3: v = osf_pkg::CFG_W'($urandom_range(1, 4));
      default: v = 7'd64;
    endcase
    write_reg(osf_pkg::REG_FRAMES, v);
  endtask

  // receiver: random stalls, none in the calm tail
  initial begin : out_side
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 6);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected frame transaction: frame_sample %h", frame_sample_o);
        errors++;
      end else begin
        got_beat = pending_beats.pop_front();
        beats_checked++;
        if (frame_sample_o !== got_beat.smp) begin
          $error("frame_sample: expected %h, actual %h", got_beat.smp, frame_sample_o);
          errors++;
        end
        if (frame_index_o !== got_beat.pos) begin
          $error("frame_index: expected %0d, actual %0d", got_beat.pos, frame_index_o);
          errors++;
        end
        if (frame_last_o !== got_beat.last) begin
          $error("frame_last: expected %0d, actual %0d", got_beat.last, frame_last_o);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int n;
    int base;
    int len;
    foreach (ring_img[i]) ring_img[i] = osf_pkg::POS_ZERO;
    wr_ptr = 0;
    since_frame = 0;
    cfg_spec = osf_pkg::SPECTRAL_RST;
    cfg_hop = osf_pkg::HOP_RST;
    cfg_blk = osf_pkg::BLOCK_RST;
    cfg_calls = osf_pkg::FRAMES_RST;

    // one-sample frames in time mode: every pattern passes untouched
    dir_rows.push_back(cfg_row(osf_pkg::REG_HOP, 7'd1));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd1));
    dir_rows.push_back(typed_row(32'h0000_0000, 1'b1, 32'h0000_0000));
    dir_rows.push_back(typed_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(typed_row(32'h7F80_0000, 1'b1, 32'h7F80_0000));
    dir_rows.push_back(typed_row(32'h7FC0_0001, 1'b1, 32'h7FC0_0001));
    dir_rows.push_back(typed_row(32'h8000_0000, 1'b1, 32'h8000_0000));
    // empty frame: sample still lands in the ring
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd0));
    dir_rows.push_back(typed_row(32'h1234_5678, 1'b0, osf_pkg::POS_ZERO));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd4));
    dir_rows.push_back(cfg_row(osf_pkg::REG_HOP, 7'd2));
    dir_rows.push_back(smp_row(32'h0000_0001));
    dir_rows.push_back(smp_row(32'h7F7F_FFFF));
    dir_rows.push_back(smp_row(32'hFF80_0000));
    dir_rows.push_back(smp_row(32'h0080_0000));
    // hop of zero acts as one
    dir_rows.push_back(cfg_row(osf_pkg::REG_HOP, 7'd0));
    dir_rows.push_back(smp_row(32'h3F80_0000));
    // spectral frame reaching back over the non-finite words, then again once scrubbed
    dir_rows.push_back(cfg_row(osf_pkg::REG_SPECTRAL, 7'd1));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd16));
    dir_rows.push_back(smp_row(32'h7FFF_FFFF));
    dir_rows.push_back(smp_row(32'h4049_0FDB));
    // spectral block over capacity: samples dropped outright
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd65));
    dir_rows.push_back(typed_row(32'h1111_1111, 1'b0, osf_pkg::POS_ZERO));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd127));
    dir_rows.push_back(typed_row(32'h2222_2222, 1'b0, osf_pkg::POS_ZERO));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd64));
    dir_rows.push_back(smp_row(32'hC000_0000));
    // upper data bits of the mode register are dropped: back to time mode
    dir_rows.push_back(cfg_row(osf_pkg::REG_SPECTRAL, 7'h7E));
    dir_rows.push_back(cfg_row(osf_pkg::REG_FRAMES, 7'd0));
    dir_rows.push_back(typed_row(32'h3333_3333, 1'b0, osf_pkg::POS_ZERO));
    // hop lowered below the pending count fires on the next sample
    dir_rows.push_back(cfg_row(osf_pkg::REG_FRAMES, 7'd64));
    dir_rows.push_back(cfg_row(osf_pkg::REG_HOP, 7'd5));
    dir_rows.push_back(cfg_row(osf_pkg::REG_BLOCK, 7'd3));
    dir_rows.push_back(smp_row(32'hBF80_0000));
    dir_rows.push_back(smp_row(32'h0000_00FF));
    dir_rows.push_back(smp_row(32'h7F80_0001));
    dir_rows.push_back(cfg_row(osf_pkg::REG_HOP, 7'd2));
    dir_rows.push_back(smp_row(32'hA5A5_5A5A));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      case (r.kind)
        ROW_CFG: begin
          drain_frames();
          write_reg(r.idx, r.data);
        end
        ROW_PREDICT: begin
          send_sample(r.smp, 1'b1, n);
          sender_gap();
        end
        default: begin
          send_sample(r.smp, 1'b0, n);
          if (r.one_beat) begin
            got_beat.smp = r.want;
            got_beat.pos = '0;
            got_beat.last = 1'b1;
            pending_beats.push_back(got_beat);
          end
          sender_gap();
        end
      endcase
    end

    // random phases, the first at the reset register values
    base = samples_sent - samples_dropped;
    while (samples_sent - samples_dropped - base < RANDOM_ITEMS) begin
      drain_frames();
      if (phase_cnt == 0) begin
        write_reg(osf_pkg::REG_SPECTRAL, osf_pkg::CFG_W'(osf_pkg::SPECTRAL_RST));
        write_reg(osf_pkg::REG_HOP, osf_pkg::HOP_RST);
        write_reg(osf_pkg::REG_BLOCK, osf_pkg::BLOCK_RST);
        write_reg(osf_pkg::REG_FRAMES, osf_pkg::FRAMES_RST);
        len = 32;
      end else begin
        random_setting();
        len = $urandom_range(4, 24);
      end
      phase_cnt++;
      calm_tail = (samples_sent - samples_dropped - base) >= RANDOM_ITEMS - CALM_ITEMS;
      for (int j = 0; j < len; j++) begin
        send_sample(rand_sample(), 1'b1, n);
        if (!calm_tail && j == len / 2 && $urandom_range(0, 2) == 0) drain_frames();
        else sender_gap();
      end
    end

    in_valid_i <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending_beats.size() != 0; n++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      $error("%0d frame transactions never arrived", pending_beats.size());
      errors++;
    end
    $display("%0d samples sent (%0d dropped by spectral size), %0d frame transactions checked",
             samples_sent, samples_dropped, beats_checked);
    $display("%0d random register phases over time and spectral framing", phase_cnt);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $error("timeout with %0d frame transactions outstanding", pending_beats.size());
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
design/osf_pkg.sv
design/osf_ring.sv
design/osf_emit.sv
design/overlap_save_framer.sv
test/overlap_save_framer_tb.sv
